FILE: rtl/chdg_pkg.sv
// Shared types, constants and the arctangent table for the compass heading unit.
package chdg_pkg;

    // Register map of the configuration port.
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_X_OFFSET = 1'b0;
    localparam logic REG_Y_OFFSET = 1'b1;

    // Fixed-point formats of the arctangent chain.
    localparam int GUARD_BITS   = 32;
    localparam int ANG_FRAC     = 40;
    localparam int ANGLE_W      = ANG_FRAC + 8;
    localparam int CORDIC_STEPS = 32;

    // Radians to degrees, resolved at elaboration.
    localparam real PI_VAL      = 3.14159265358979323846;
    localparam real DEG_PER_RAD = 180.0 / PI_VAL;

    // Heading width and the fixed headings.
    localparam int HEAD_W = 9;
    localparam logic [HEAD_W-1:0] DEG_0   = 9'd0;
    localparam logic [HEAD_W-1:0] DEG_45  = 9'd45;
    localparam logic [HEAD_W-1:0] DEG_90  = 9'd90;
    localparam logic [HEAD_W-1:0] DEG_179 = 9'd179;
    localparam logic [HEAD_W-1:0] DEG_180 = 9'd180;
    localparam logic [HEAD_W-1:0] DEG_270 = 9'd270;
    localparam logic [HEAD_W-1:0] DEG_359 = 9'd359;
    localparam logic [HEAD_W-1:0] DEG_360 = 9'd360;

    // Sample class, decided once at the front and carried down the chain.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ANGLE  = 2'd0;
    localparam kind_t KIND_X_ZERO = 2'd1;
    localparam kind_t KIND_Y_ZERO = 2'd2;
    localparam kind_t KIND_EQUAL  = 2'd3;

    typedef struct packed {
        kind_t kind;
        logic  x_pos;
        logic  y_pos;
    } tag_t;

    // atan(2^-step) in degrees with ANG_FRAC fractional bits, rounded.
    function automatic logic [ANGLE_W-1:0] atan_step(input int step);
        real r;
        r = $atan(2.0 ** (-step)) * DEG_PER_RAD * (2.0 ** ANG_FRAC);
        return ANGLE_W'(longint'(r));
    endfunction

endpackage

FILE: rtl/chdg_apb_regs.sv
// Configuration registers for the hard-iron offsets behind an APB-style port.
module chdg_apb_regs #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [chdg_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [chdg_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [chdg_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic signed [SAMPLE_WIDTH-1:0]       x_offset,
    output logic signed [SAMPLE_WIDTH-1:0]       y_offset
);
    import chdg_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] x_off_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_off_reg;
    logic                           wr_en;
    logic                           sel_y;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel_y  = (paddr[REG_SEL_BIT] == REG_Y_OFFSET);

    // Register writes; address bit REG_SEL_BIT selects the register and the low address bits are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_off_reg <= '0;
            y_off_reg <= '0;
        end
        else if (wr_en)
        begin
            if (sel_y)
            begin
                y_off_reg <= pwdata[SAMPLE_WIDTH-1:0];
            end
            else
            begin
                x_off_reg <= pwdata[SAMPLE_WIDTH-1:0];
            end
        end
    end

    // Read data is the register value, sign-extended to the bus width.
    always_comb
    begin
        if (paddr[REG_SEL_BIT] == REG_X_OFFSET)
        begin
            prdata = {{(APB_DATA_W-SAMPLE_WIDTH){x_off_reg[SAMPLE_WIDTH-1]}}, x_off_reg};
        end
        else
        begin
            prdata = {{(APB_DATA_W-SAMPLE_WIDTH){y_off_reg[SAMPLE_WIDTH-1]}}, y_off_reg};
        end
    end

    assign x_offset = x_off_reg;
    assign y_offset = y_off_reg;

endmodule

FILE: rtl/chdg_front.sv
// Front stage: offset removal, magnitudes, sample class and chain entry vectors.
module chdg_front #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int VEC_W        = SAMPLE_WIDTH + 35
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          v_in,
    input  logic signed [SAMPLE_WIDTH-1:0] x_raw,
    input  logic signed [SAMPLE_WIDTH-1:0] y_raw,
    input  logic signed [SAMPLE_WIDTH-1:0] x_offset,
    input  logic signed [SAMPLE_WIDTH-1:0] y_offset,
    output logic                          v_out,
    output logic signed [VEC_W-1:0]       x_out,
    output logic signed [VEC_W-1:0]       y_out,
    output chdg_pkg::tag_t                tag_out
);
    import chdg_pkg::*;

    logic signed [SAMPLE_WIDTH:0]   dx;
    logic signed [SAMPLE_WIDTH:0]   dy;
    logic signed [SAMPLE_WIDTH:0]   dx_neg;
    logic signed [SAMPLE_WIDTH:0]   dy_neg;
    logic [SAMPLE_WIDTH-1:0]        ax;
    logic [SAMPLE_WIDTH-1:0]        ay;
    tag_t                           tag_next;
    logic                           v_reg;
    logic signed [VEC_W-1:0]        x_reg;
    logic signed [VEC_W-1:0]        y_reg;
    tag_t                           tag_reg;

    // Exact differences, one bit wider than the samples.
    assign dx = {x_raw[SAMPLE_WIDTH-1], x_raw} - {x_offset[SAMPLE_WIDTH-1], x_offset};
    assign dy = {y_raw[SAMPLE_WIDTH-1], y_raw} - {y_offset[SAMPLE_WIDTH-1], y_offset};
    assign dx_neg = -dx;
    assign dy_neg = -dy;

    // Magnitudes always fit in SAMPLE_WIDTH bits.
    assign ax = dx[SAMPLE_WIDTH] ? dx_neg[SAMPLE_WIDTH-1:0] : dx[SAMPLE_WIDTH-1:0];
    assign ay = dy[SAMPLE_WIDTH] ? dy_neg[SAMPLE_WIDTH-1:0] : dy[SAMPLE_WIDTH-1:0];

    // Classify the sample: axis cases, equal magnitudes or a real angle.
    always_comb
    begin
        tag_next.x_pos = !dx[SAMPLE_WIDTH] && (dx != '0);
        tag_next.y_pos = !dy[SAMPLE_WIDTH] && (dy != '0);
        if (dx == '0)
        begin
            tag_next.kind = KIND_X_ZERO;
        end
        else if (dy == '0)
        begin
            tag_next.kind = KIND_Y_ZERO;
        end
        else if (ax == ay)
        begin
            tag_next.kind = KIND_EQUAL;
        end
        else
        begin
            tag_next.kind = KIND_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    // Vectors enter the chain scaled up by the guard bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= signed'({3'b000, ax, {GUARD_BITS{1'b0}}});
            y_reg   <= signed'({3'b000, ay, {GUARD_BITS{1'b0}}});
            tag_reg <= tag_next;
        end
    end

    assign v_out   = v_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign tag_out = tag_reg;

`ifndef SYNTH
    // A sample that needs the arctangent has two nonzero magnitudes.
    a_angle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg && tag_reg.kind == KIND_ANGLE) |-> (x_reg != '0 && y_reg != '0))
        else $error("angle sample entered the chain with a zero component");
`endif

endmodule

FILE: rtl/chdg_cordic_cell.sv
// One vectoring step of the arctangent chain, with its own pipeline register.
module chdg_cordic_cell #(
    parameter int STEP  = 0,
    parameter int VEC_W = 51
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   v_in,
    input  logic signed [VEC_W-1:0]                x_in,
    input  logic signed [VEC_W-1:0]                y_in,
    input  logic signed [chdg_pkg::ANGLE_W-1:0]    z_in,
    input  chdg_pkg::tag_t                         tag_in,
    output logic                                   v_out,
    output logic signed [VEC_W-1:0]                x_out,
    output logic signed [VEC_W-1:0]                y_out,
    output logic signed [chdg_pkg::ANGLE_W-1:0]    z_out,
    output chdg_pkg::tag_t                         tag_out
);
    import chdg_pkg::*;

    localparam logic signed [ANGLE_W-1:0] ATAN = signed'(atan_step(STEP));

    logic signed [VEC_W-1:0]   xs;
    logic signed [VEC_W-1:0]   ys;
    logic                      rot_down;
    logic signed [VEC_W-1:0]   x_next;
    logic signed [VEC_W-1:0]   y_next;
    logic signed [ANGLE_W-1:0] z_next;
    logic                      v_reg;
    logic signed [VEC_W-1:0]   x_reg;
    logic signed [VEC_W-1:0]   y_reg;
    logic signed [ANGLE_W-1:0] z_reg;
    tag_t                      tag_reg;

    // Arithmetic shifts round toward minus infinity.
    assign xs       = x_in >>> STEP;
    assign ys       = y_in >>> STEP;
    assign rot_down = !y_in[VEC_W-1] && (y_in != '0);

    // Rotate toward the x axis and accumulate the angle in degrees.
    always_comb
    begin
        if (rot_down)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= tag_in;
        end
    end

    assign v_out   = v_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign tag_out = tag_reg;

`ifndef SYNTH
    // The x component of a vector in the right half-plane stays positive.
    a_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg && tag_reg.kind == KIND_ANGLE) |-> (!x_reg[VEC_W-1] && x_reg != '0))
        else $error("cordic x component left the right half-plane");
`endif

endmodule

FILE: rtl/chdg_back.sv
// Back end: quadrant placement, truncation, output register and skid buffer.
module chdg_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                v_in,
    input  logic signed [chdg_pkg::ANGLE_W-1:0] z_in,
    input  chdg_pkg::tag_t                      tag_in,
    input  logic                                stall,
    output logic                                room,
    output logic                                out_valid,
    output logic [chdg_pkg::HEAD_W-1:0]         heading_deg
);
    import chdg_pkg::*;

    logic [6:0]        q7;
    logic              frac;
    logic [HEAD_W-1:0] q;
    logic              f;
    logic [HEAD_W-1:0] head_next;
    logic              hv_reg;
    logic [HEAD_W-1:0] hd_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [HEAD_W-1:0] out_head_reg;
    logic [HEAD_W-1:0] out_head_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [HEAD_W-1:0] skid_head_reg;
    logic [HEAD_W-1:0] skid_head_next;
    logic              en;
    logic              incoming;
    logic              take;

    // Integer degrees and a flag for a nonzero fraction.
    assign q7   = z_in[ANG_FRAC+6:ANG_FRAC];
    assign frac = |z_in[ANG_FRAC-1:0];

    // Equal magnitudes give exactly 45; a slightly negative angle clamps to 0.
    always_comb
    begin
        if (tag_in.kind == KIND_EQUAL)
        begin
            q = DEG_45;
            f = 1'b0;
        end
        else if (z_in[ANGLE_W-1])
        begin
            q = DEG_0;
            f = 1'b0;
        end
        else
        begin
            q = {2'b00, q7};
            f = frac;
        end
    end

    // Place the angle by quadrant; reflected angles truncate toward zero.
    always_comb
    begin
        case (tag_in.kind)
            KIND_X_ZERO:
            begin
                head_next = tag_in.y_pos ? DEG_90 : DEG_270;
            end
            KIND_Y_ZERO:
            begin
                head_next = tag_in.x_pos ? DEG_0 : DEG_180;
            end
            default:
            begin
                if (tag_in.x_pos && tag_in.y_pos)
                begin
                    head_next = q;
                end
                else if (tag_in.y_pos)
                begin
                    head_next = (f ? DEG_179 : DEG_180) - q;
                end
                else if (!tag_in.x_pos)
                begin
                    head_next = DEG_180 + q;
                end
                else
                begin
                    head_next = (f ? DEG_359 : DEG_360) - q;
                end
            end
        endcase
    end

    // The whole pipeline moves while the skid buffer is empty.
    assign en       = !skid_valid_reg;
    assign room     = en;
    assign incoming = en && hv_reg;
    assign take     = out_valid_reg && !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= 1'b0;
        end
        else if (en)
        begin
            hv_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hd_reg <= head_next;
        end
    end

    // Output register with a one-beat skid stage behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_head_next   = out_head_reg;
        skid_valid_next = skid_valid_reg;
        skid_head_next  = skid_head_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_head_next   = skid_head_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (incoming)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_head_next  = hd_reg;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_head_next  = hd_reg;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_head_reg  <= out_head_next;
        skid_head_reg <= skid_head_next;
    end

    assign out_valid   = out_valid_reg;
    assign heading_deg = out_head_reg;

`ifndef SYNTH
    // The skid stage only holds a beat while the output register is full.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    // The skid stage fills only when a waiting beat was stalled.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && stall))
        else $error("skid stage filled without a stalled output beat");

    // Every heading delivered lies in the compass range.
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_head_reg < DEG_360))
        else $error("heading out of range");
`endif

endmodule

FILE: rtl/compass_heading_from_xy_unit.sv
// Top level of the compass heading unit: registers, front, arctangent chain, back end.
//
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_stall  x_raw, y_raw (SAMPLE_WIDTH, signed)
//  out       source     out_valid/out_stall  heading_deg (9 bits, 0..359)
//  config    APB slave  psel/penable/pready  x_offset at 0x0, y_offset at 0x4
//
// One sample is accepted per cycle while in_stall is low; a heading passes the
// front stage, 32 vectoring cells, the placement stage and the output register.
// The depth is set by the chain of 32 vectoring cells, one rotation each.
// Reset clears all valid bits and both offsets; no clearing pass is needed.
// in_stall is the registered skid-full flag: a stalled output beat lets one more
// beat leave the chain into the skid stage before the whole pipeline holds.
module compass_heading_from_xy_unit #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [chdg_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [chdg_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [chdg_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        x_raw,
    input  logic signed [SAMPLE_WIDTH-1:0]        y_raw,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [chdg_pkg::HEAD_W-1:0]           heading_deg
);
    import chdg_pkg::*;

    localparam int VEC_W = SAMPLE_WIDTH + GUARD_BITS + 3;

    logic signed [SAMPLE_WIDTH-1:0] x_offset;
    logic signed [SAMPLE_WIDTH-1:0] y_offset;
    logic                           room;
    logic                           cv   [CORDIC_STEPS+1];
    logic signed [VEC_W-1:0]        cx   [CORDIC_STEPS+1];
    logic signed [VEC_W-1:0]        cy   [CORDIC_STEPS+1];
    logic signed [ANGLE_W-1:0]      cz   [CORDIC_STEPS+1];
    tag_t                           ctag [CORDIC_STEPS+1];

    // Hard-iron offset registers.
    chdg_apb_regs #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .x_offset (x_offset),
        .y_offset (y_offset)
    );

    assign in_stall = !room;

    // Offset removal and classification feed the first cell.
    chdg_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .VEC_W        (VEC_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (room),
        .v_in     (in_valid),
        .x_raw    (x_raw),
        .y_raw    (y_raw),
        .x_offset (x_offset),
        .y_offset (y_offset),
        .v_out    (cv[0]),
        .x_out    (cx[0]),
        .y_out    (cy[0]),
        .tag_out  (ctag[0])
    );

    assign cz[0] = '0;

    // Row of vectoring cells, each handing its beat to the next every cycle while the skid stage is empty.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        chdg_cordic_cell #(
            .STEP  (i),
            .VEC_W (VEC_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (room),
            .v_in    (cv[i]),
            .x_in    (cx[i]),
            .y_in    (cy[i]),
            .z_in    (cz[i]),
            .tag_in  (ctag[i]),
            .v_out   (cv[i+1]),
            .x_out   (cx[i+1]),
            .y_out   (cy[i+1]),
            .z_out   (cz[i+1]),
            .tag_out (ctag[i+1])
        );
    end

    // Quadrant placement and output buffering.
    chdg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .v_in        (cv[CORDIC_STEPS]),
        .z_in        (cz[CORDIC_STEPS]),
        .tag_in      (ctag[CORDIC_STEPS]),
        .stall       (out_stall),
        .room        (room),
        .out_valid   (out_valid),
        .heading_deg (heading_deg)
    );

endmodule
